>>> sv/hsdu_pkg.sv
package hsdu_pkg;

    localparam int WEIGHT_BITS_DEF = 12;

    // The shared multiplier takes 33-bit signed operands so that the unsigned
    // decay rate fits as a positive number.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W - 16;

    localparam int RATE_W = 16;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_ACC    = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        feature_index;
        logic [31:0]        index_offset;
        logic signed [31:0] feature_value;
        logic signed [31:0] update_step;
        logic               last_feature;
    } in_t;

    typedef struct packed {
        logic signed [31:0] dot_sum;
        logic               saturated_flag;
    } out_t;

endpackage

>>> sv/hsdu_wmem.sv
module hsdu_wmem #(
    parameter int ADDR_W = hsdu_pkg::WEIGHT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [31:0]       wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [31:0]       rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/hsdu_mul.sv
module hsdu_mul (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [hsdu_pkg::MUL_W-1:0]    op_a,
    input  logic signed [hsdu_pkg::MUL_W-1:0]    op_b,
    output logic signed [hsdu_pkg::PROD_W-1:0]   prod
);

    logic signed [2*hsdu_pkg::MUL_W-1:0] full;
    logic signed [hsdu_pkg::PROD_W-1:0]  prod_reg;

    assign full = op_a * op_b;

    // Dropping the low 16 bits of a two's complement product rounds toward
    // minus infinity.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= full[2*hsdu_pkg::MUL_W-1:16];
        end
    end

    assign prod = prod_reg;

endmodule

>>> sv/hashed_sparse_dot_update.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  hsdu_pkg::in_t  (one sparse feature)
// m_        out        m_valid / m_ready  hsdu_pkg::out_t (finished dot product)
// cfg_      in         cfg_we             cfg_wdata (regularization rate)
// A write ends in S_IDLE, an accumulate takes S_MUL1, S_ACC, an update S_MUL1,
// S_MUL2, S_UPD; the shared 33x33 multiplier and registered RAM read set this.
// Reset clears the running sum, the rate and the control state; the weight
// memory is not cleared and must be written before it is read.
// A last accumulate waits in its final cycle while an earlier result is still
// held on m_ and not taken.
module hashed_sparse_dot_update #(
    parameter int WEIGHT_BITS = hsdu_pkg::WEIGHT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  hsdu_pkg::in_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output hsdu_pkg::out_t              m_data,
    input  logic                        cfg_we,
    input  logic [hsdu_pkg::RATE_W-1:0] cfg_wdata
);

    localparam int MW = hsdu_pkg::MUL_W;
    localparam int PW = hsdu_pkg::PROD_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [hsdu_pkg::RATE_W-1:0] rate_reg;
    logic [1:0]                  op_reg;
    logic [WEIGHT_BITS-1:0]      addr_reg;
    logic signed [31:0]          val_reg;
    logic signed [31:0]          step_reg;
    logic                        last_reg;
    logic signed [PW-1:0]        grad_reg;
    logic signed [63:0]          sum_reg, sum_next;
    logic                        m_valid_reg;
    hsdu_pkg::out_t              m_data_reg;

    logic                   accept;
    logic [WEIGHT_BITS-1:0] addr_now;
    logic                   mem_we;
    logic [WEIGHT_BITS-1:0] mem_waddr;
    logic [31:0]            mem_wdata;
    logic                   mem_re;
    logic signed [31:0]     w;
    logic                   mul_en;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   prod;

    logic signed [64:0] sum_wide;
    logic signed [63:0] sum_sat;
    logic               sum_big;
    logic signed [31:0] dot_clip;
    logic signed [PW+1:0] upd_wide;
    logic signed [31:0]   upd_clip;
    logic                 stall_out;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign addr_now = s_data.feature_index[WEIGHT_BITS-1:0]
                    + s_data.index_offset[WEIGHT_BITS-1:0];

    assign mem_re    = accept && (s_data.opcode == hsdu_pkg::OP_ACC
                                  || s_data.opcode == hsdu_pkg::OP_UPDATE);
    assign mem_we    = (accept && s_data.opcode == hsdu_pkg::OP_WRITE)
                       || (state_reg == S_UPD);
    assign mem_waddr = (state_reg == S_UPD) ? addr_reg : addr_now;
    assign mem_wdata = (state_reg == S_UPD) ? upd_clip : s_data.feature_value;

    hsdu_wmem #(
        .ADDR_W (WEIGHT_BITS)
    ) u_wmem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_now),
        .rdata (w)
    );

    // The first pass forms weight*value or step*value; the second pass of an
    // update forms rate*weight while the gradient waits in grad_reg.
    always_comb begin
        mul_en = (state_reg == S_MUL1) || (state_reg == S_MUL2);
        if (state_reg == S_MUL2) begin
            mul_a = {{(MW-hsdu_pkg::RATE_W){1'b0}}, rate_reg};
        end else begin
            mul_a = {{(MW-32){val_reg[31]}}, val_reg};
        end
        if (state_reg == S_MUL1 && op_reg == hsdu_pkg::OP_UPDATE) begin
            mul_b = {{(MW-32){step_reg[31]}}, step_reg};
        end else begin
            mul_b = {{(MW-32){w[31]}}, w};
        end
    end

    hsdu_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Running sum saturated at 64 bits, then clipped to 32 bits for dot_sum.
    always_comb begin
        sum_wide = {sum_reg[63], sum_reg} + {{(65-PW){prod[PW-1]}}, prod};
        if (sum_wide[64] != sum_wide[63]) begin
            sum_sat = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sum_sat = sum_wide[63:0];
        end
        sum_big = !((&sum_sat[63:31]) || !(|sum_sat[63:31]));
        if (sum_big) begin
            dot_clip = sum_sat[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            dot_clip = sum_sat[31:0];
        end
    end

    always_comb begin
        upd_wide = {{(PW-30){w[31]}}, w}
                 + {{2{grad_reg[PW-1]}}, grad_reg}
                 - {{2{prod[PW-1]}}, prod};
        if ((&upd_wide[PW+1:31]) || !(|upd_wide[PW+1:31])) begin
            upd_clip = upd_wide[31:0];
        end else begin
            upd_clip = upd_wide[PW+1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
    end

    assign stall_out = last_reg && m_valid_reg && !m_ready;

    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (mem_re) begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                state_next = (op_reg == hsdu_pkg::OP_ACC) ? S_ACC : S_MUL2;
            end
            S_ACC: begin
                if (!stall_out) begin
                    state_next = S_IDLE;
                    sum_next   = last_reg ? 64'sd0 : sum_sat;
                end
            end
            S_MUL2: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sum_reg     <= 64'sd0;
            rate_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            if (cfg_we) begin
                rate_reg <= cfg_wdata;
            end
            if (state_reg == S_ACC && last_reg && !stall_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_data.opcode;
            addr_reg <= addr_now;
            val_reg  <= s_data.feature_value;
            step_reg <= s_data.update_step;
            last_reg <= s_data.last_feature;
        end
        if (state_reg == S_MUL2) begin
            grad_reg <= prod;
        end
        if (state_reg == S_ACC && last_reg && !stall_out) begin
            m_data_reg.dot_sum        <= dot_clip;
            m_data_reg.saturated_flag <= sum_big;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
